/* rtl/core/msg_pkg.sv */
// ----------------------------------------------------------------------------
// msg_pkg - shared types and arithmetic for the masked sobel gradient block
// constants, pixel word layout, issue and result records, gray and sobel math
// ----------------------------------------------------------------------------
package msg_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int AW        = $clog2(MAX_WIDTH);          // column index bits
	localparam int CFG_W     = 12;                          // image_width register
	localparam int EW        = $clog2(MAX_WIDTH + 1);
	localparam int XW        = (EW > CFG_W) ? EW : CFG_W;   // width compare bits
	localparam int CH_W      = 8;
	localparam int GW        = 15;                          // gray value bits
	localparam int PW        = GW + 1;                      // stored word: mask, gray
	localparam int SW        = 17;                          // weighted sum bits
	localparam int DW        = SW + 1;                      // signed difference bits
	localparam int GRW       = 17;                          // result gradient bits
	localparam int RESET_WIDTH = 640;
	localparam logic [GRW-1:0] GRAD_CEIL = '1;
	localparam int GRAD_MAX  = 4 * 25500;                   // largest unmasked response
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);
	localparam int QCW       = $clog2(QDEPTH + 1);

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} op_t;

	typedef logic [PW-1:0] word_t;
	typedef logic [2:0][PW-1:0] col_t;    // index: upper, centre, lower row

	// one item on its way through the memory stage
	typedef struct packed {
		logic          wr;     // pixel: write back the shifted rows
		logic [AW-1:0] addr;
		word_t         word;   // new lower-row word, zero for a drain
		logic          e1;     // result with the centre at window column 1
		logic          e2;     // result with the centre at window column 2
		logic          lp1;    // left neighbour present for the first result
		logic          tp;     // upper row present
		logic          bp;     // lower row present
		logic          fin;    // second result closes the frame
	} iss_t;

	typedef struct packed {
		logic [GRW-1:0] gv;
		logic [GRW-1:0] gh;
		logic           masked;
		logic           fin;
	} res_t;

	function automatic logic [GW-1:0] gray_of(logic [CH_W-1:0] c0, logic [CH_W-1:0] c1,
			logic [CH_W-1:0] c2);
		logic [GW-1:0] a;
		logic [GW-1:0] b;
		logic [GW-1:0] c;
		a = GW'(c0) * GW'(27);
		b = GW'(c1) * GW'(67);
		c = GW'(c2) * GW'(6);
		return a + b + c;
	endfunction

	// outer taps weight 1 when present, middle tap weight 2
	function automatic logic [SW-1:0] wsum(word_t a, word_t b, word_t c, logic ea, logic ec);
		logic [SW-1:0] sa;
		logic [SW-1:0] sb;
		logic [SW-1:0] sc;
		sa = ea ? SW'(a[GW-1:0]) : '0;
		sb = SW'(b[GW-1:0]) << 1;
		sc = ec ? SW'(c[GW-1:0]) : '0;
		return sa + sb + sc;
	endfunction

	function automatic res_t sobel(col_t l, col_t m, col_t r, logic lp, logic rp, logic tp,
			logic bp, logic fin);
		logic [SW-1:0]        csl;
		logic [SW-1:0]        csr;
		logic [SW-1:0]        rs0;
		logic [SW-1:0]        rs2;
		logic signed [DW-1:0] gx;
		logic signed [DW-1:0] gy;
		logic [DW-1:0]        ax;
		logic [DW-1:0]        ay;
		res_t                 o;
		csl = wsum(l[0], l[1], l[2], tp, bp);
		csr = wsum(r[0], r[1], r[2], tp, bp);
		rs0 = wsum(l[0], m[0], r[0], lp, rp);
		rs2 = wsum(l[2], m[2], r[2], lp, rp);
		gx  = signed'({1'b0, (lp ? csl : SW'(0))}) - signed'({1'b0, (rp ? csr : SW'(0))});
		gy  = signed'({1'b0, (tp ? rs0 : SW'(0))}) - signed'({1'b0, (bp ? rs2 : SW'(0))});
		ax  = gx[DW-1] ? DW'(-gx) : DW'(gx);
		ay  = gy[DW-1] ? DW'(-gy) : DW'(gy);
		o.masked = m[1][PW-1];
		o.fin    = fin;
		o.gh     = o.masked ? GRAD_CEIL : ax[GRW-1:0];
		o.gv     = o.masked ? GRAD_CEIL : ay[GRW-1:0];
		return o;
	endfunction

endpackage

/* rtl/core/msg_ram.sv */
// ----------------------------------------------------------------------------
// msg_ram - generic single-clock ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module msg_ram #(
	parameter int  WIDTH = 32,
	parameter int  DEPTH = 2048,
	localparam int RAW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [RAW-1:0]   waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [RAW-1:0]   raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/msg_ctrl.sv */
// ----------------------------------------------------------------------------
// msg_ctrl - frame position tracking and item issue
// width register, column/row/drain counters, gray conversion of new pixels
// ----------------------------------------------------------------------------
module msg_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [msg_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      fire,
	input  msg_pkg::op_t              opcode,
	input  logic [msg_pkg::CH_W-1:0]  chan0,
	input  logic [msg_pkg::CH_W-1:0]  chan1,
	input  logic [msg_pkg::CH_W-1:0]  chan2,
	input  logic [msg_pkg::CH_W-1:0]  alpha,
	output logic                      go,
	output msg_pkg::iss_t             iss
);
	import msg_pkg::*;

	logic [CFG_W-1:0] wid_q;
	logic [AW-1:0]    col_q;
	logic [AW-1:0]    drn_q;
	logic [1:0]       row_q;     // rows done, saturating at two

	logic [XW-1:0] wid_x;
	logic [XW-1:0] eff_w;
	logic [XW-1:0] last_col;
	logic          restart;
	logic          drain_ok;
	logic [AW-1:0] c;
	logic [1:0]    row;
	logic          last;
	word_t         word;

	always_comb begin
		wid_x = XW'(wid_q);
		if (wid_x == '0) begin
			eff_w = XW'(1);
		end else if (wid_x > XW'(MAX_WIDTH)) begin
			eff_w = XW'(MAX_WIDTH);
		end else begin
			eff_w = wid_x;
		end
		last_col = eff_w - XW'(1);

		restart  = (drn_q != '0);
		drain_ok = (col_q == '0) && (row_q != 2'd0);
		if (opcode == OP_PIXEL) begin
			c   = restart ? '0 : col_q;
			row = restart ? 2'd0 : row_q;
		end else begin
			c   = drn_q;
			row = row_q;
		end
		last = (XW'(c) == last_col);
		word = {(alpha == '0), gray_of(chan0, chan1, chan2)};

		go       = fire && ((opcode == OP_PIXEL) || drain_ok);
		iss.wr   = (opcode == OP_PIXEL);
		iss.addr = c;
		iss.word = (opcode == OP_PIXEL) ? word : '0;
		iss.tp   = (row == 2'd2);
		if (opcode == OP_PIXEL) begin
			iss.e1  = (row != 2'd0) && (c != '0);
			iss.e2  = (row != 2'd0) && last;
			iss.bp  = 1'b1;
			iss.fin = 1'b0;
		end else begin
			iss.e1  = (c != '0);
			iss.e2  = last;
			iss.bp  = 1'b0;
			iss.fin = last;
		end
		iss.lp1 = (c > AW'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wid_q <= CFG_W'(RESET_WIDTH);
			col_q <= '0;
			drn_q <= '0;
			row_q <= 2'd0;
		end else if (cfg_we) begin
			wid_q <= cfg_wdata;
			col_q <= '0;
			drn_q <= '0;
			row_q <= 2'd0;
		end else if (go) begin
			if (opcode == OP_PIXEL) begin
				drn_q <= '0;
				col_q <= last ? '0 : AW'(c + 1'b1);
				row_q <= (last && (row != 2'd2)) ? 2'(row + 2'd1) : row;
			end else if (last) begin
				col_q <= '0;
				drn_q <= '0;
				row_q <= 2'd0;
			end else begin
				drn_q <= AW'(c + 1'b1);
			end
		end
	end

endmodule

/* rtl/core/msg_win.sv */
// ----------------------------------------------------------------------------
// msg_win - 3x3 window registers and sobel evaluation
// shifts in one column per item and evaluates both possible results
// ----------------------------------------------------------------------------
module msg_win (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clr,
	input  logic           adv,
	input  msg_pkg::word_t up,
	input  msg_pkg::word_t mid,
	input  msg_pkg::iss_t  iss,
	output msg_pkg::res_t  res_a,
	output msg_pkg::res_t  res_b
);
	import msg_pkg::*;

	col_t win_q [3];   // window columns, oldest first
	col_t nxt   [3];

	always_comb begin
		nxt[0] = win_q[1];
		nxt[1] = win_q[2];
		nxt[2] = {iss.word, mid, up};
		// centre one column back, all three columns in the image on the right
		res_a = sobel(nxt[0], nxt[1], nxt[2], iss.lp1, 1'b1, iss.tp, iss.bp, 1'b0);
		// centre at the newest column, which is the last of the row
		res_b = sobel(nxt[1], nxt[2], '0, iss.e1, 1'b0, iss.tp, iss.bp, iss.fin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i] <= '0;
			end
		end else if (clr) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i] <= nxt[i];
			end
		end
	end

endmodule

/* rtl/core/msg_outq.sv */
// ----------------------------------------------------------------------------
// msg_outq - result queue
// small register queue taking up to two results and giving one per cycle
// ----------------------------------------------------------------------------
module msg_outq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push_a,
	input  msg_pkg::res_t           din_a,
	input  logic                    push_b,
	input  msg_pkg::res_t           din_b,
	input  logic                    pop,
	output msg_pkg::res_t           dout,
	output logic [msg_pkg::QCW-1:0] count
);
	import msg_pkg::*;

	res_t            mem_q [QDEPTH];
	logic [QAW-1:0]  wp_q;
	logic [QAW-1:0]  rp_q;
	logic [QCW-1:0]  cnt_q;
	logic [QAW-1:0]  wp_b;

	assign wp_b  = push_a ? QAW'(wp_q + 1'b1) : wp_q;
	assign dout  = mem_q[rp_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wp_q] <= din_a;
		end
		if (push_b) begin
			mem_q[wp_b] <= din_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= QAW'(wp_q + QAW'(push_a) + QAW'(push_b));
			rp_q  <= QAW'(rp_q + QAW'(pop));
			cnt_q <= QCW'(cnt_q + QCW'(push_a) + QCW'(push_b) - QCW'(pop));
		end
	end

endmodule

/* rtl/core/masked_sobel_gradient_top.sv */
// ----------------------------------------------------------------------------
// masked_sobel_gradient_top - streaming 3x3 sobel gradients with alpha mask
// raster pixels in, absolute horizontal and vertical gradients out
// ----------------------------------------------------------------------------
// The block takes one transaction per clock, pixels in raster order or drain
// ticks, and keeps that rate as long as results are taken at one per clock.
// Each pixel turns into a gray value in hundredths (27*chan0 + 67*chan1 +
// 6*chan2); results trail the input by one row, so row 0 of a frame gives
// nothing and the pixel at row r column c gives the result for (r-1, c-1),
// plus the result for (r-1, c) when c is the last column. After the last pixel
// of a frame send image_width drain ticks to flush the final row; frame_end
// (tlast) marks the last result. A pixel whose alpha is zero comes out with
// masked set and both gradients at 131071. The two previous rows sit in one
// 2048 x 32 ram, read at the current column by every transaction and
// rewritten by every pixel; its single read and single write port set the
// one-item-per-clock figure. Results are queued as the memory stage advances.
// The ram needs no clearing pass after reset. A row end produces two
// results, so a four-entry output queue absorbs the burst; with an output
// side that keeps up, input never stalls. image_width is written through
// cfg_we/cfg_wdata while the block is idle and restarts the frame; zero acts
// as one and values above 2048 act as 2048.
// ----------------------------------------------------------------------------
module masked_sobel_gradient_top (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration: image width
	input  logic                      cfg_we,
	input  logic [msg_pkg::CFG_W-1:0] cfg_wdata,
	// input stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [31:0]               s_tdata,   // chan0, chan1, chan2, alpha
	input  logic                      s_tuser,   // opcode: pixel or drain tick
	// output stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [39:0]               m_tdata,   // grad_horiz, grad_vert, zero pad
	output logic                      m_tuser,   // masked
	output logic                      m_tlast    // frame_end
);
	import msg_pkg::*;

	// input side
	logic fire;
	logic go;
	iss_t iss;

	// memory stage: item whose rows are being read
	logic             valid_s1;
	iss_t             iss_s1;
	logic             adv_s1;
	logic [1:0]       nres_s1;

	// ram and forwarding
	logic [2*PW-1:0]  rdata;
	logic [2*PW-1:0]  rd_eff;
	logic [2*PW-1:0]  wdata;
	logic             fwd_q;
	logic [2*PW-1:0]  fwd_d_q;

	// results
	res_t             res_a;
	res_t             res_b;
	res_t             res_out;
	logic [QCW-1:0]   qcount;
	logic             pop;

	assign fire     = s_tvalid && s_tready;
	assign s_tready = !valid_s1 || adv_s1;

	msg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.opcode    (op_t'(s_tuser)),
		.chan0     (s_tdata[7:0]),
		.chan1     (s_tdata[15:8]),
		.chan2     (s_tdata[23:16]),
		.alpha     (s_tdata[31:24]),
		.go        (go),
		.iss       (iss)
	);

	// ram word: upper half is the row two back, lower half the previous row
	assign rd_eff = fwd_q ? fwd_d_q : rdata;
	assign wdata  = {rd_eff[PW-1:0], iss_s1.word};

	msg_ram #(
		.WIDTH (2 * PW),
		.DEPTH (MAX_WIDTH)
	) u_rows (
		.clk   (clk),
		.we    (adv_s1 && iss_s1.wr),
		.waddr (iss_s1.addr),
		.wdata (wdata),
		.re    (go),
		.raddr (iss.addr),
		.rdata (rdata)
	);

	// results this item pushes; advance only with room in the queue, counting
	// no credit for a pop in the same cycle so ready has no path from m_tready
	assign nres_s1 = 2'(iss_s1.e1) + 2'(iss_s1.e2);
	assign adv_s1  = valid_s1 && ((QCW + 1)'(qcount) + (QCW + 1)'(nres_s1)
			<= (QCW + 1)'(QDEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			if (go) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			// same column written back while being read again (one-pixel rows)
			if (go) begin
				fwd_q <= adv_s1 && iss_s1.wr && (iss_s1.addr == iss.addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			iss_s1  <= iss;
			fwd_d_q <= wdata;
		end
	end

	msg_win u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (cfg_we),
		.adv    (adv_s1),
		.up     (rd_eff[2*PW-1:PW]),
		.mid    (rd_eff[PW-1:0]),
		.iss    (iss_s1),
		.res_a  (res_a),
		.res_b  (res_b)
	);

	assign pop = m_tvalid && m_tready;

	msg_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push_a (adv_s1 && iss_s1.e1),
		.din_a  (res_a),
		.push_b (adv_s1 && iss_s1.e2),
		.din_b  (res_b),
		.pop    (pop),
		.dout   (res_out),
		.count  (qcount)
	);

	assign m_tvalid = (qcount != '0);
	assign m_tdata  = {6'd0, res_out.gv, res_out.gh};
	assign m_tuser  = res_out.masked;
	assign m_tlast  = res_out.fin;

endmodule

/* rtl/core/msg_checker.sv */
// ----------------------------------------------------------------------------
// msg_checker - port-level checks for the masked sobel gradient block
// output hold under stall and gradient ranges, bound to the top level
// ----------------------------------------------------------------------------
module msg_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_we,
	input logic [msg_pkg::CFG_W-1:0] cfg_wdata,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [31:0]               s_tdata,
	input logic                      s_tuser,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [39:0]               m_tdata,
	input logic                      m_tuser,
	input logic                      m_tlast
);
	import msg_pkg::*;

	logic [GRW-1:0] gh;
	logic [GRW-1:0] gv;

	assign gh = m_tdata[GRW-1:0];
	assign gv = m_tdata[2*GRW-1:GRW];

	// a stalled result keeps its place and content
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output transaction changed under stall");

	// masked centre forces both gradients to the ceiling
	a_masked_ceil: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (gh == GRAD_CEIL) && (gv == GRAD_CEIL))
		else $error("masked result without ceiling gradients");

	// an unmasked response never exceeds four full-scale gray steps
	a_unmasked_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (gh <= GRW'(GRAD_MAX)) && (gv <= GRW'(GRAD_MAX)))
		else $error("unmasked gradient out of range");

	// ready has no path from m_tready; this checks it stays known after a low
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |=> !$isunknown(s_tready))
		else $error("input ready unknown");

endmodule

bind masked_sobel_gradient_top msg_checker u_msg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_we    (cfg_we),
	.cfg_wdata (cfg_wdata),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.s_tdata   (s_tdata),
	.s_tuser   (s_tuser),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser),
	.m_tlast   (m_tlast)
);

/* tb/masked_sobel_gradient_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_sobel_gradient_checker - gradient predictor and result scoreboard
// watches the configuration port and both streams, keeps its own copy of the
// row store, window and frame counters, and compares every output transaction
// field by field with the oldest predicted gradient
// ----------------------------------------------------------------------------
module masked_sobel_gradient_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [msg_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [31:0]               s_tdata,   // chan0, chan1, chan2, alpha
	input  logic                      s_tuser,   // opcode
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [39:0]               m_tdata,   // grad_horiz, grad_vert, zero pad
	input  logic                      m_tuser,   // masked
	input  logic                      m_tlast,   // frame_end
	output int                        mismatches,
	output int                        n_pending,
	output int                        grads_checked,
	output int                        frames_closed
);

	localparam int LW         = msg_pkg::MAX_WIDTH;
	localparam int ROW_LIMIT  = 65535;
	localparam int PRINT_CAP  = 40;

	typedef struct packed {
		logic [16:0] gh;
		logic [16:0] gv;
		logic        masked;
		logic        fin;
	} grad_t;

	logic [msg_pkg::CFG_W-1:0] width_reg;
	logic [15:0]               rows_store [0:2*LW-1];   // previous row, then the one before
	logic [15:0]               win [0:2][0:2];          // upper, centre, lower by oldest..newest
	int unsigned               col_pos;
	int unsigned               rows_done;
	int unsigned               drain_pos;
	grad_t                     expected_grads [$];

	function automatic int unsigned cur_width();
		if (width_reg == 0) return 1;
		if (width_reg > LW) return LW;
		return width_reg;
	endfunction

	task automatic clear_frame();
		col_pos   = 0;
		rows_done = 0;
		drain_pos = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				win[i][j] = '0;
	endtask

	task automatic shift_in(logic [15:0] up, logic [15:0] mid, logic [15:0] low);
		for (int i = 0; i < 3; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = up;
		win[1][2] = mid;
		win[2][2] = low;
	endtask

	// centre at window column cc, absent neighbours drop out of the sums
	function automatic grad_t sobel_at(int cc, bit lp, bit rp, bit tp, bit bp, bit fin);
		int    wt [3];
		bit    rowp [3];
		bit    colp [3];
		int    gx;
		int    gy;
		int    g;
		int    col;
		grad_t r;
		wt   = '{1, 2, 1};
		rowp = '{tp, 1'b1, bp};
		colp = '{lp, 1'b1, rp};
		gx   = 0;
		gy   = 0;
		r.fin = fin;
		if (win[1][cc][15]) begin
			r.gh     = msg_pkg::GRAD_CEIL;
			r.gv     = msg_pkg::GRAD_CEIL;
			r.masked = 1'b1;
		end else begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					col = cc - 1 + j;
					if (rowp[i] && colp[j] && col >= 0 && col <= 2) begin
						g = int'(win[i][col][14:0]);
						if (j == 0) gx += wt[i] * g;
						if (j == 2) gx -= wt[i] * g;
						if (i == 0) gy += wt[j] * g;
						if (i == 2) gy -= wt[j] * g;
					end
				end
			end
			if (gx < 0) gx = -gx;
			if (gy < 0) gy = -gy;
			r.gh     = gx[16:0];
			r.gv     = gy[16:0];
			r.masked = 1'b0;
		end
		return r;
	endfunction

	task automatic push_results(int unsigned c, int unsigned w, bit tp, bit bp, bit fin);
		if (c >= 1) expected_grads.push_back(sobel_at(1, c >= 2, 1'b1, tp, bp, 1'b0));
		if (c == w - 1) expected_grads.push_back(sobel_at(2, c >= 1, 1'b0, tp, bp, fin));
	endtask

	task automatic take_pixel(logic [31:0] d);
		int unsigned w;
		int unsigned c;
		int unsigned gray;
		logic [15:0] word;
		logic [15:0] up;
		logic [15:0] mid;
		w    = cur_width();
		gray = 27 * d[7:0] + 67 * d[15:8] + 6 * d[23:16];
		word = {d[31:24] == 8'd0, gray[14:0]};
		// a pixel after a partial drain starts a fresh frame
		if (drain_pos != 0) clear_frame();
		c = col_pos;
		if (c >= w) c = 0;
		up  = rows_store[LW + c];
		mid = rows_store[c];
		rows_store[LW + c] = mid;
		rows_store[c]      = word;
		shift_in(up, mid, word);
		if (rows_done >= 1) push_results(c, w, rows_done >= 2, 1'b1, 1'b0);
		c++;
		if (c >= w) begin
			c = 0;
			if (rows_done < ROW_LIMIT) rows_done++;
		end
		col_pos = c;
	endtask

	task automatic take_drain();
		int unsigned w;
		int unsigned c;
		w = cur_width();
		// ignored mid-row or before any complete row
		if (col_pos != 0 || rows_done == 0) return;
		c = drain_pos;
		if (c >= w) c = 0;
		shift_in(rows_store[LW + c], rows_store[c], 16'h0000);
		push_results(c, w, rows_done >= 2, 1'b0, c == w - 1);
		c++;
		if (c >= w) clear_frame();
		else drain_pos = c;
	endtask

	task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
		if (got !== want) begin
			if (mismatches < PRINT_CAP)
				$display("%0t: result %0d %s expected %0d got %0d", $time, grads_checked,
					name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		grad_t want;
		grad_t got;
		if (!arst_n) begin
			width_reg = msg_pkg::RESET_WIDTH;
			clear_frame();
			expected_grads.delete();
			for (int i = 0; i < 2 * LW; i++) rows_store[i] = '0;
			mismatches    = 0;
			n_pending     = 0;
			grads_checked = 0;
			frames_closed = 0;
		end else begin
			// compare first so a result never meets an expectation made this edge
			if (m_tvalid && m_tready) begin
				got.gh     = m_tdata[16:0];
				got.gv     = m_tdata[33:17];
				got.masked = m_tuser;
				got.fin    = m_tlast;
				if (expected_grads.size() == 0) begin
					if (mismatches < PRINT_CAP)
						$display("%0t: unexpected result gh=%0d gv=%0d masked=%0b last=%0b",
							$time, got.gh, got.gv, got.masked, got.fin);
					mismatches++;
				end else begin
					want = expected_grads.pop_front();
					check_field("grad_horiz", want.gh, got.gh);
					check_field("grad_vert", want.gv, got.gv);
					check_field("masked", 17'(want.masked), 17'(got.masked));
					check_field("frame_end", 17'(want.fin), 17'(got.fin));
					if (want.fin) frames_closed++;
				end
				grads_checked++;
			end
			if (cfg_we) begin
				width_reg = cfg_wdata;
				clear_frame();
			end
			if (s_tvalid && s_tready) begin
				if (msg_pkg::op_t'(s_tuser) == msg_pkg::OP_PIXEL) take_pixel(s_tdata);
				else take_drain();
			end
			n_pending = expected_grads.size();
		end
	end

endmodule

/* tb/masked_sobel_gradient_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_sobel_gradient_top_tb - stream test of the masked sobel gradient block
// directed frames for the drain and mask corners, then random raster frames
// over many image widths with idle gaps on both sides and one long output
// hold-off; a separate checker predicts and scores every result
// ----------------------------------------------------------------------------
module masked_sobel_gradient_top_tb;

	localparam int HOLD_CYCLES  = 300;    // long output hold-off
	localparam int STALL_LIMIT  = 4000;   // cycles with no transaction before giving up
	localparam int IDLE_PCT     = 23;
	localparam int RANDOM_ITEMS = 950;
	localparam int SMALL_WIDTH  = 64;     // widths above this do not count toward the item goal
	localparam int DRAIN_SETTLE = 8;      // covers the memory stage plus queue
	localparam int END_SETTLE   = 20;

	// how a random frame is disturbed
	typedef enum int {
		FRAME_CLEAN,
		FRAME_MIDROW_DRAIN,   // stray drain ticks inside rows, ignored
		FRAME_CUT_DRAIN,      // drain stopped early, next pixel opens a new frame
		FRAME_EXTRA_DRAIN     // drain ticks after the frame closed, ignored
	} frame_kind_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [msg_pkg::CFG_W-1:0] cfg_wdata;
	logic                      s_tvalid;
	logic                      s_tready;
	logic [31:0]               s_tdata;    // chan0, chan1, chan2, alpha
	logic                      s_tuser;    // opcode
	logic                      m_tvalid;
	logic                      m_tready;
	logic [39:0]               m_tdata;    // grad_horiz, grad_vert, zero pad
	logic                      m_tuser;    // masked
	logic                      m_tlast;    // frame_end

	int mismatches;
	int n_pending;
	int grads_checked;
	int frames_closed;

	bit gaps_on;        // random idling on both sides
	bit hold_pending;   // asks the receiver for one long hold-off
	int idle_cycles;
	int useful_items;   // pixels and flushing drain ticks at small widths
	int items_sent;
	int phase_no;

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	masked_sobel_gradient_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	masked_sobel_gradient_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.mismatches    (mismatches),
		.n_pending     (n_pending),
		.grads_checked (grads_checked),
		.frames_closed (frames_closed)
	);

	// ------------------------------------------------------------------
	// watchdog: a run that stops moving transactions is a failure
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results still due",
					$time, idle_cycles, n_pending);
				$display("simulation failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: random back-pressure, plus one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				m_tready <= 1'b0;
				// sender keeps offering, so the output queue fills and s_tready drops
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// sender helpers
	// ------------------------------------------------------------------

	function automatic logic [31:0] pack_pixel(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
			logic [7:0] al);
		return {al, c2, c1, c0};
	endfunction

	// byte biased toward the extremes
	function automatic logic [7:0] rand_byte();
		int unsigned r;
		r = $urandom_range(7);
		if (r == 0) return 8'd0;
		if (r == 1) return 8'd255;
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [31:0] rand_pixel();
		logic [7:0] al;
		al = ($urandom_range(7) == 0) ? 8'd0 : rand_byte();
		return pack_pixel(rand_byte(), rand_byte(), rand_byte(), al);
	endfunction

	// called at a rising edge, returns at the edge where the transaction completes
	task automatic send_item(msg_pkg::op_t op, logic [31:0] data);
		if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		// s_tready is settled by the falling edge
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic send_drains(int n);
		repeat (n) send_item(msg_pkg::OP_DRAIN, $urandom());
	endtask

	// write image_width once every expected result is out and the block is quiet
	task automatic set_width(int unsigned v);
		s_tvalid <= 1'b0;
		do @(negedge clk); while (n_pending != 0);
		repeat (DRAIN_SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= msg_pkg::CFG_W'(v);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic frame_kind_t pick_kind();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 70) return FRAME_CLEAN;
		if (r < 80) return FRAME_MIDROW_DRAIN;
		if (r < 90) return FRAME_CUT_DRAIN;
		return FRAME_EXTRA_DRAIN;
	endfunction

	// rows of random pixels, then the drain ticks that flush the last row
	task automatic send_frame(int w, int rows, frame_kind_t kind);
		for (int r = 0; r < rows; r++) begin
			for (int c = 0; c < w; c++) begin
				if (kind == FRAME_MIDROW_DRAIN && c > 0 && $urandom_range(19) == 0)
					send_item(msg_pkg::OP_DRAIN, $urandom());
				send_item(msg_pkg::OP_PIXEL, rand_pixel());
			end
		end
		if (kind == FRAME_CUT_DRAIN) send_drains($urandom_range(0, w - 1));
		else send_drains(w);
		if (kind == FRAME_EXTRA_DRAIN) send_drains($urandom_range(1, 2));
		if (w <= SMALL_WIDTH) useful_items += w * rows + w;
	endtask

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin
		int unsigned wval;
		int          weff;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;
		gaps_on      = 1'b1;
		hold_pending = 1'b0;
		idle_cycles  = 0;
		useful_items = 0;
		items_sent   = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: three-pixel rows
		set_width(3);
		send_item(msg_pkg::OP_DRAIN, '0);                                    // no rows yet
		send_item(msg_pkg::OP_PIXEL, pack_pixel(8'd255, 8'd255, 8'd255, 8'd255));
		send_item(msg_pkg::OP_DRAIN, '1);                                    // mid-row, ignored
		send_item(msg_pkg::OP_PIXEL, pack_pixel(8'd0, 8'd0, 8'd0, 8'd0));     // masked
		send_item(msg_pkg::OP_PIXEL, pack_pixel(8'd255, 8'd0, 8'd0, 8'd1));
		send_item(msg_pkg::OP_PIXEL, pack_pixel(8'd0, 8'd255, 8'd0, 8'd128));
		send_item(msg_pkg::OP_PIXEL, pack_pixel(8'd0, 8'd0, 8'd255, 8'd0));   // masked centre
		send_item(msg_pkg::OP_PIXEL, pack_pixel(8'd255, 8'd255, 8'd255, 8'd255));
		send_item(msg_pkg::OP_PIXEL, pack_pixel(8'd0, 8'd0, 8'd0, 8'd255));
		send_item(msg_pkg::OP_PIXEL, pack_pixel(8'd255, 8'd255, 8'd255, 8'd255));
		send_item(msg_pkg::OP_PIXEL, pack_pixel(8'd0, 8'd0, 8'd0, 8'd255));
		send_drains(3);                                                      // closes the frame
		// two rows, drain cut short by the next frame's first pixel
		repeat (6) send_item(msg_pkg::OP_PIXEL, rand_pixel());
		send_drains(1);
		// single-row frame: only the centre row takes part
		repeat (3) send_item(msg_pkg::OP_PIXEL, rand_pixel());
		send_drains(3);

		// random phases, each with its own image width
		phase_no = 0;
		while (useful_items < RANDOM_ITEMS) begin
			phase_no++;
			// no idling on either side over a long stretch
			gaps_on = !(phase_no >= 4 && phase_no <= 6);
			case (phase_no)
				1:       wval = 0;       // acts as one
				2:       wval = 8;
				3:       wval = 1;
				5:       wval = 4095;    // clamps to the widest row
				7:       wval = msg_pkg::MAX_WIDTH;
				default: wval = ($urandom_range(9) < 7) ? $urandom_range(1, 16)
					: $urandom_range(17, SMALL_WIDTH);
			endcase
			set_width(wval);
			weff = (wval == 0) ? 1 : (wval > msg_pkg::MAX_WIDTH) ? msg_pkg::MAX_WIDTH : wval;
			if (phase_no == 2) begin
				hold_pending = 1'b1;
				repeat (3) send_frame(weff, 4, FRAME_CLEAN);
			end else if (phase_no == 5) begin
				send_frame(weff, 1, FRAME_CLEAN);
			end else if (phase_no == 7) begin
				// one full wide row and the start of the next, cut by the next write
				repeat (weff + 3) send_item(msg_pkg::OP_PIXEL, rand_pixel());
			end else begin
				repeat ($urandom_range(1, 3))
					send_frame(weff, $urandom_range(1, 4), pick_kind());
			end
		end

		s_tvalid <= 1'b0;
		do @(negedge clk); while (n_pending != 0);
		repeat (END_SETTLE) @(posedge clk);

		$display("%0d input transactions over %0d width settings, %0d results checked",
			items_sent, phase_no + 1, grads_checked);
		$display("%0d frames closed by drain, widths 0 to 4095, one long output hold-off",
			frames_closed);
		if (mismatches == 0 && n_pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
